// File: rtl/rft_pkg.sv
// Shared types and constants for the rail fence transposer.
// No dependencies; imported by the controller, datapath and top level.
package rft_pkg;

  localparam int MAX_LEN   = 64;
  localparam int MAX_RAILS = 16;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = $clog2(MAX_LEN + 1);
  localparam int RAIL_W    = $clog2(MAX_RAILS);
  localparam int RC_W      = 5;
  localparam int SYM_W     = 8;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // store the accepted word
    logic setup;      // prepare the drain walk
    logic clear;      // drop the message without output
    logic rail_step;  // move to the next rail
    logic rail_take;  // point at the head of the current rail
    logic read;       // read the stores at the pointer
    logic emit;       // present one result word and advance
  } rft_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic inorder;      // pass-through order
    logic present_cur;  // current rail holds bytes
    logic at_tail;      // pointer sits on the tail of its rail
    logic last_one;     // one word left to emit
    logic count_zero;   // nothing stored
  } rft_stat_t;

  // rail register clamped to 1..MAX_RAILS
  function automatic logic [RC_W-1:0] eff_rails(input logic [RC_W-1:0] rc);
    logic [RC_W-1:0] r;
    r = rc;
    if (rc == '0) r = RC_W'(1);
    if (rc > RC_W'(MAX_RAILS)) r = RC_W'(MAX_RAILS);
    return r;
  endfunction

endpackage

// File: rtl/rft_ctrl.sv
// Sequencing state machine for load and drain of the transposer.
// Depends on rft_pkg for the command and status structs.
module rft_ctrl import rft_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_final_req,
  input  rft_stat_t stat,
  output rft_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RAIL,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_final_req) state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (stat.count_zero) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cmd.setup = 1'b1;
          state_nxt = stat.inorder ? ST_READ : ST_RAIL;
        end
      end
      ST_RAIL: begin
        if (stat.present_cur) begin
          cmd.rail_take = 1'b1;
          state_nxt     = ST_READ;
        end else begin
          cmd.rail_step = 1'b1;
        end
      end
      ST_READ: begin
        cmd.read  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (stat.last_one) state_nxt = ST_IDLE;
        else if (stat.inorder || !stat.at_tail) state_nxt = ST_READ;
        else state_nxt = ST_RAIL;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy    <= (state_nxt != ST_IDLE);
    end
  end

endmodule

// File: rtl/rft_dp.sv
// Datapath: byte store, per-rail linked lists, zigzag tagging, result register.
// Depends on rft_pkg; driven by rft_ctrl commands.
module rft_dp import rft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [RC_W-1:0]  cfg_data,
  input  logic [SYM_W-1:0] in_symbol,
  input  rft_cmd_t         cmd,
  output rft_stat_t        stat,
  output logic             out_valid,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_last,
  output logic             out_truncated
);

  // memories
  logic [SYM_W-1:0]  byte_mem [MAX_LEN];
  logic [ADDR_W-1:0] next_mem [MAX_LEN];

  // per-rail list ends
  logic [ADDR_W-1:0] head_r [MAX_RAILS];
  logic [ADDR_W-1:0] tail_r [MAX_RAILS];

  logic [RC_W-1:0]   rail_count_r;
  logic [CNT_W-1:0]  byte_count_r;
  logic [RAIL_W-1:0] cur_rail_r;
  logic              down_r;
  logic              overflow_r;
  logic [MAX_RAILS-1:0] present_r;
  logic [ADDR_W-1:0] ptr_r;
  logic [RAIL_W-1:0] rail_r;
  logic [CNT_W-1:0]  remain_r;
  logic [SYM_W-1:0]  byte_rd_r;
  logic [ADDR_W-1:0] next_rd_r;
  logic              out_valid_r, out_last_r, out_trunc_r;
  logic [SYM_W-1:0]  out_symbol_r;

  logic [RC_W-1:0]   rails;
  logic              room;
  logic [RAIL_W-1:0] tag, cr_a, cur_rail_nxt;
  logic              md_a, down_nxt;
  logic [RAIL_W-1:0] tail_sel;
  logic [ADDR_W-1:0] tail_rd;
  logic [ADDR_W-1:0] wr_addr;
  logic              store_en;

  assign rails    = eff_rails(rail_count_r);
  assign room     = (byte_count_r < CNT_W'(MAX_LEN));
  assign wr_addr  = byte_count_r[ADDR_W-1:0];
  assign store_en = cmd.load && room;

  // zigzag rail tag for the incoming word
  always_comb begin
    cr_a         = cur_rail_r;
    md_a         = down_r;
    tag          = '0;
    cur_rail_nxt = '0;
    down_nxt     = 1'b1;
    if (rails > RC_W'(1)) begin
      if ({1'b0, cur_rail_r} >= (rails - RC_W'(1))) begin
        cr_a = RAIL_W'(rails - RC_W'(1));
        md_a = 1'b0;
      end
      if (cr_a == '0) md_a = 1'b1;
      tag          = cr_a;
      cur_rail_nxt = md_a ? (cr_a + RAIL_W'(1)) : (cr_a - RAIL_W'(1));
      down_nxt     = md_a;
    end
  end

  // one tail read port, shared by load and drain
  assign tail_sel = cmd.load ? tag : rail_r;
  assign tail_rd  = tail_r[tail_sel];

  // status
  assign stat.inorder     = (rails <= RC_W'(1)) || (byte_count_r < CNT_W'(rails));
  assign stat.present_cur = present_r[rail_r];
  assign stat.at_tail     = (ptr_r == tail_rd);
  assign stat.last_one    = (remain_r == CNT_W'(1));
  assign stat.count_zero  = (byte_count_r == '0);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rail_count_r <= RC_W'(1);
      byte_count_r <= '0;
      cur_rail_r   <= '0;
      down_r       <= 1'b1;
      overflow_r   <= 1'b0;
      present_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_we) rail_count_r <= cfg_data;
      if (cmd.load) begin
        if (room) begin
          byte_count_r    <= byte_count_r + CNT_W'(1);
          cur_rail_r      <= cur_rail_nxt;
          down_r          <= down_nxt;
          present_r[tag]  <= 1'b1;
        end else begin
          overflow_r <= 1'b1;
        end
      end
      if (cmd.clear || (cmd.emit && stat.last_one)) begin
        byte_count_r <= '0;
        cur_rail_r   <= '0;
        down_r       <= 1'b1;
        overflow_r   <= 1'b0;
        present_r    <= '0;
      end
    end
  end

  // drain walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      ptr_r    <= '0;
      rail_r   <= '0;
      remain_r <= byte_count_r;
    end
    if (cmd.rail_step) rail_r <= rail_r + RAIL_W'(1);
    if (cmd.rail_take) ptr_r  <= head_r[rail_r];
    if (cmd.emit) begin
      out_symbol_r <= byte_rd_r;
      out_last_r   <= stat.last_one;
      out_trunc_r  <= overflow_r;
      remain_r     <= remain_r - CNT_W'(1);
      if (stat.inorder) ptr_r <= ptr_r + ADDR_W'(1);
      else if (stat.at_tail) rail_r <= rail_r + RAIL_W'(1);
      else ptr_r <= next_rd_r;
    end
  end

  // list ends per rail
  always_ff @(posedge clk) begin
    if (store_en) begin
      tail_r[tag] <= wr_addr;
      if (!present_r[tag]) head_r[tag] <= wr_addr;
    end
  end

  // byte and link stores
  always_ff @(posedge clk) begin
    if (store_en) begin
      byte_mem[wr_addr] <= in_symbol;
      if (present_r[tag]) next_mem[tail_rd] <= wr_addr;
    end
    if (cmd.read) begin
      byte_rd_r <= byte_mem[ptr_r];
      next_rd_r <= next_mem[ptr_r];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_symbol    = out_symbol_r;
  assign out_last      = out_last_r;
  assign out_truncated = out_trunc_r;

endmodule

// File: rtl/rail_fence_transposer_unit.sv
// A non-final word is stored without leaving idle; after a final word the drain runs setup,
// then (in rail order) a search for a rail with bytes, then per result a store read and then
// the result register, plus a rail step for each further rail visited. Each message is
// loaded, then drained, and no word is taken while it drains; the receiver cannot stall.
// Reset (rst_n low, synchronous) empties the message and sets the rail count to one;
// byte and link stores are not cleared.
module rail_fence_transposer_unit import rft_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [SYM_W-1:0] in_symbol,
  input  logic             in_final_req,
  output logic             out_valid,
  output logic [SYM_W-1:0] out_symbol,
  output logic             out_last,
  output logic             out_truncated,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RC_W-1:0]  cfg_data
);

  rft_cmd_t  cmd;
  rft_stat_t stat;

  // register write always taken
  assign cfg_ready = 1'b1;

  rft_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_final_req (in_final_req),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy)
  );

  rft_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .in_symbol     (in_symbol),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_symbol    (out_symbol),
    .out_last      (out_last),
    .out_truncated (out_truncated)
  );

`ifndef SYNTHESIS
  // last word of a message leaves the block idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy) else $error("busy after last word");

  // results never come in consecutive cycles
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back-to-back result words");

  // a non-final word never starts a drain
  a_nonfinal: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_final_req |=> !busy) else $error("busy after non-final word");

  // drain starts only from a final word
  a_drain_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_final_req)) else $error("drain without final word");
`endif

endmodule

// File: test/testbench.sv
// Self-checking bench for rail_fence_transposer_unit: a negedge driver fed from a word queue,
// a posedge monitor with a built-in zigzag predictor, and a cycle-count watchdog.
// Depends on rft_pkg and the top level of the transposer only.
module testbench import rft_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_TAIL    = 40;

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_SETTLE, ACT_PHASE} act_kind_t;

  typedef struct {
    act_kind_t        kind;
    logic [SYM_W-1:0] symbol;
    logic             final_req;
    int               arg;
  } action_t;

  typedef struct {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             truncated;
  } result_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [SYM_W-1:0] in_symbol;
  logic             in_final_req;
  logic             out_valid;
  logic [SYM_W-1:0] out_symbol;
  logic             out_last;
  logic             out_truncated;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [RC_W-1:0]  cfg_data;

  rail_fence_transposer_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_symbol     (in_symbol),
    .in_final_req  (in_final_req),
    .out_valid     (out_valid),
    .out_symbol    (out_symbol),
    .out_last      (out_last),
    .out_truncated (out_truncated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // stimulus and expectations
  action_t pending[$];
  result_t results_due[$];

  // predictor copy of the block state
  logic [SYM_W-1:0] msg_bytes [MAX_LEN];
  int               msg_tags  [MAX_LEN];
  int               msg_len      = 0;
  int               rail_pos     = 0;
  logic             heading_down = 1'b1;
  logic             dropped_any  = 1'b0;
  logic [RC_W-1:0]  rail_setting = RC_W'(1);

  // bookkeeping
  int   cycle_count    = 0;
  int   fail_count     = 0;
  int   words_in       = 0;
  int   words_out      = 0;
  int   messages_done  = 0;
  int   rail_writes    = 0;
  int   trunc_messages = 0;
  int   sender_idle_pct = 0;
  int   settle_left    = SETTLE_CYCLES;
  logic word_taken     = 1'b0;
  logic cfg_taken      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // zigzag tagging of one accepted word; the final word releases the whole message
  task automatic fold_in(input logic [SYM_W-1:0] sym, input logic fin);
    int      rails;
    int      tag;
    result_t r;
    result_t batch[$];
    rails = (rail_setting == '0) ? 1 :
            (int'(rail_setting) > MAX_RAILS) ? MAX_RAILS : int'(rail_setting);
    if (msg_len < MAX_LEN) begin
      tag = 0;
      if (rails > 1) begin
        // a rail beyond a newly lowered top is clamped and turns upward
        if (rail_pos >= rails - 1) begin
          rail_pos     = rails - 1;
          heading_down = 1'b0;
        end
        if (rail_pos == 0) heading_down = 1'b1;
        tag      = rail_pos;
        rail_pos = heading_down ? rail_pos + 1 : rail_pos - 1;
      end else begin
        rail_pos     = 0;
        heading_down = 1'b1;
      end
      msg_bytes[msg_len] = sym;
      msg_tags[msg_len]  = tag;
      msg_len++;
    end else begin
      dropped_any = 1'b1;
    end
    if (fin) begin
      r.last      = 1'b0;
      r.truncated = dropped_any;
      if (rails <= 1 || msg_len < rails) begin
        for (int i = 0; i < msg_len; i++) begin
          r.symbol = msg_bytes[i];
          batch.push_back(r);
        end
      end else begin
        // rail by rail over every tag value, arrival order within a rail
        for (int t = 0; t < MAX_RAILS; t++)
          for (int i = 0; i < msg_len; i++)
            if (msg_tags[i] == t) begin
              r.symbol = msg_bytes[i];
              batch.push_back(r);
            end
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) results_due.push_back(batch[k]);
      if (dropped_any) trunc_messages++;
      messages_done++;
      msg_len      = 0;
      rail_pos     = 0;
      heading_down = 1'b1;
      dropped_any  = 1'b0;
    end
  endtask

  // monitor: results against the oldest expectation, then accepted words and writes
  always @(posedge clk) begin : observe
    result_t want;
    if (rst_n) begin
      cycle_count++;
      if (out_valid) begin
        words_out++;
        if (results_due.size() == 0) begin
          $error("unexpected word: out_symbol %0h out_last %0b out_truncated %0b",
                 out_symbol, out_last, out_truncated);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_symbol !== want.symbol) begin
            $error("out_symbol: expected %0h, actual %0h", want.symbol, out_symbol);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            fail_count++;
          end
          if (out_truncated !== want.truncated) begin
            $error("out_truncated: expected %0b, actual %0b", want.truncated, out_truncated);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        word_taken = 1'b1;
        words_in++;
        fold_in(in_symbol, in_final_req);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken    = 1'b1;
        rail_setting = cfg_data;
        rail_writes++;
      end
    end
  end

  // driver: one update per signal per falling edge
  always @(negedge clk) begin : drive
    logic             n_start;
    logic [SYM_W-1:0] n_sym;
    logic             n_fin;
    logic             n_cv;
    logic [RC_W-1:0]  n_cd;
    if (rst_n) begin
      n_start = start;
      n_sym   = in_symbol;
      n_fin   = in_final_req;
      n_cv    = cfg_valid;
      n_cd    = cfg_data;
      if (word_taken) n_start = 1'b0;
      if (cfg_taken) n_cv = 1'b0;
      word_taken = 1'b0;
      cfg_taken  = 1'b0;
      if (!n_start && !n_cv && pending.size() > 0) begin
        case (pending[0].kind)
          ACT_WORD: begin
            if ($urandom_range(99) >= sender_idle_pct) begin
              n_start = 1'b1;
              n_sym   = pending[0].symbol;
              n_fin   = pending[0].final_req;
              void'(pending.pop_front());
            end
          end
          ACT_CFG: begin
            n_cv = 1'b1;
            n_cd = RC_W'(pending[0].arg);
            void'(pending.pop_front());
          end
          ACT_SETTLE: begin
            // hold off until every expected word is out, then let the block go quiet
            if (results_due.size() != 0) begin
              settle_left = SETTLE_CYCLES;
            end else if (settle_left > 0) begin
              settle_left--;
            end else begin
              settle_left = SETTLE_CYCLES;
              void'(pending.pop_front());
            end
          end
          ACT_PHASE: begin
            sender_idle_pct = pending[0].arg;
            void'(pending.pop_front());
          end
          default: void'(pending.pop_front());
        endcase
      end
      start        <= n_start;
      in_symbol    <= n_sym;
      in_final_req <= n_fin;
      cfg_valid    <= n_cv;
      cfg_data     <= n_cd;
    end
  end

  task automatic add_word(input int sym, input logic fin);
    action_t a;
    a.kind      = ACT_WORD;
    a.symbol    = SYM_W'(sym);
    a.final_req = fin;
    a.arg       = 0;
    pending.push_back(a);
  endtask

  task automatic add_ctl(input act_kind_t kind, input int arg);
    action_t a;
    a.kind      = kind;
    a.symbol    = '0;
    a.final_req = 1'b0;
    a.arg       = arg;
    pending.push_back(a);
  endtask

  // register writes only once the block has gone quiet
  task automatic add_rails(input int value);
    add_ctl(ACT_SETTLE, 0);
    add_ctl(ACT_CFG, value);
  endtask

  function automatic int pick_rails();
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0:       return 0;
      1:       return $urandom_range(17, 31);
      2:       return MAX_RAILS;
      3:       return 1;
      default: return $urandom_range(2, 15);
    endcase
  endfunction

  initial begin : stimulus
    int phase_pct [3];
    int phase_words;
    int len;
    int split;
    phase_pct = '{29, 0, 0};
    phase_pct[1] = 45;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_symbol    = '0;
    in_final_req = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;

    // directed: pass-through at reset setting, with extreme byte values
    add_word(8'h00, 1'b0);
    add_word(8'hff, 1'b1);
    // rail count zero behaves as one rail
    add_rails(0);
    add_word(8'ha5, 1'b0);
    add_word(8'h5a, 1'b1);
    // three rails over seven bytes: a full bounce
    add_rails(3);
    for (int i = 0; i < 7; i++) add_word(8'h10 + i, i == 6);
    // fewer bytes than rails
    add_rails(4);
    add_word(8'h01, 1'b0);
    add_word(8'h80, 1'b1);
    // rail count lowered mid-message
    add_rails(5);
    for (int i = 0; i < 3; i++) add_word(8'h30 + i, 1'b0);
    add_rails(2);
    for (int i = 0; i < 3; i++) add_word(8'h40 + i, i == 2);
    // saturating count with a one-byte message, then back to one rail
    add_rails(31);
    add_word(8'h7f, 1'b1);
    add_rails(1);
    add_word(8'hc3, 1'b1);

    // random messages over three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      add_ctl(ACT_PHASE, phase_pct[ph]);
      phase_words = 0;
      while (phase_words < 124) begin
        if ($urandom_range(2) == 0) add_rails(pick_rails());
        if ($urandom_range(7) == 0) add_ctl(ACT_SETTLE, 0);
        // now and then a long message, which may overflow the store
        len   = ($urandom_range(11) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 24);
        split = ($urandom_range(9) == 0 && len > 2) ? $urandom_range(1, len - 1) : 0;
        for (int i = 0; i < len; i++) begin
          if (split != 0 && i == split) add_rails(pick_rails());
          add_word($urandom_range(255), i == len - 1);
        end
        phase_words += len;
      end
    end

    repeat (7) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending.size() > 0 || start || cfg_valid) @(posedge clk);
    while (results_due.size() > 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("Ran %0d messages (%0d truncated): %0d words in, %0d words out, %0d rail writes",
             messages_done, trunc_messages, words_in, words_out, rail_writes);
    $display("Rail counts swept from zero to 31, sender idling at 29, 45 and 0 percent");
    if (fail_count == 0 && results_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

endmodule
